FILE: hw/rtl/utf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 / UTF-16 stream converter package
// Shared codes, the run descriptor handed from front to back, and helpers.
// ----------------------------------------------------------------------------
package utf_pkg;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CONV_MODE  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BYTE_ORDER = 1'd1;

    // Conversion modes
    localparam logic [1:0] MODE_COPY    = 2'd0;
    localparam logic [1:0] MODE_8_TO_16 = 2'd1;
    localparam logic [1:0] MODE_16_TO_8 = 2'd2;
    localparam logic [1:0] MODE_SWAP    = 2'd3;

    // Result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_LEAD  = 2'd1;
    localparam logic [1:0] ST_BAD_SURR  = 2'd2;
    localparam logic [1:0] ST_TRUNCATED = 2'd3;

    // Surrogate tags (top six bits of a UTF-16 unit)
    localparam logic [5:0]  HI_SURR_TAG = 6'b110110;
    localparam logic [5:0]  LO_SURR_TAG = 6'b110111;
    localparam logic [20:0] SUPP_BASE   = 21'h10000;

    // One input byte's worth of results, up to four
    typedef struct packed {
        logic [3:0][7:0] bytes;      // bytes[0] goes out first
        logic [1:0]      last_idx;   // index of the final result
        logic            byte_valid; // 0 for a status-only result
        logic [1:0]      status;
    } t_run;

    // Two-byte run of one UTF-16 unit in the selected byte order
    function automatic t_run unit_run(input logic [15:0] u, input logic be);
        t_run r;
        r            = '0;
        r.bytes[0]   = be ? u[15:8] : u[7:0];
        r.bytes[1]   = be ? u[7:0]  : u[15:8];
        r.last_idx   = 2'd1;
        r.byte_valid = 1'b1;
        r.status     = ST_OK;
        return r;
    endfunction

    // Four-byte run of two UTF-16 units
    function automatic t_run pair_run(input logic [15:0] u0, input logic [15:0] u1,
                                      input logic be);
        t_run r;
        r            = '0;
        r.bytes[0]   = be ? u0[15:8] : u0[7:0];
        r.bytes[1]   = be ? u0[7:0]  : u0[15:8];
        r.bytes[2]   = be ? u1[15:8] : u1[7:0];
        r.bytes[3]   = be ? u1[7:0]  : u1[15:8];
        r.last_idx   = 2'd3;
        r.byte_valid = 1'b1;
        r.status     = ST_OK;
        return r;
    endfunction

endpackage

FILE: hw/rtl/utf_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Input byte channel
// Valid/ready channel carrying one source byte and its end-of-buffer mark.
// ----------------------------------------------------------------------------
interface utf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_buffer;

    modport source (output valid, output in_byte, output end_of_buffer, input ready);
    modport sink   (input valid, input in_byte, input end_of_buffer, output ready);
endinterface

FILE: hw/rtl/utf_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying one converted byte or a status-only result.
// ----------------------------------------------------------------------------
interface utf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic [1:0] status;
    logic       last_of_run;

    modport source (output valid, output out_byte, output byte_valid, output status,
                    output last_of_run, input ready);
    modport sink   (input valid, input out_byte, input byte_valid, input status,
                    input last_of_run, output ready);
endinterface

FILE: hw/rtl/utf_cfg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface utf_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [utf_pkg::CFG_IDX_W-1:0]  reg_index;
    logic [utf_pkg::CFG_DATA_W-1:0] wr_data;

    modport source (output valid, output reg_index, output wr_data, input ready);
    modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

FILE: hw/rtl/utf_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Converter front end
// Accepts bytes and config writes, tracks stream state, emits at most one run per byte.
// ----------------------------------------------------------------------------
module utf_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    utf_in_if.sink          i_in,
    utf_cfg_if.sink         i_cfg,
    input  logic            i_q_full,
    output logic            o_push,
    output utf_pkg::t_run   o_run
);

    logic [1:0]  r_mode, n_mode;
    logic        r_be, n_be;
    logic [23:0] r_held, n_held;
    logic [1:0]  r_held_cnt, n_held_cnt;
    logic [2:0]  r_seq_len, n_seq_len;
    logic [9:0]  r_pend, n_pend;
    logic        r_have_hi, n_have_hi;
    logic        r_disc, n_disc;

    logic        take;
    logic        cfg_wr;
    logic [7:0]  b;
    logic        eob;
    logic [31:0] w32;
    logic [20:0] code4;
    logic [20:0] d4;
    logic [15:0] u3;
    logic [15:0] u2;
    logic [15:0] uc;
    logic [20:0] code_p;
    logic [2:0]  n_cnt;
    logic        do_fail;
    logic [1:0]  fail_st;
    utf_pkg::t_run run;
    logic        has_run;

    // hold input while a config write is offered so no byte is lost
    assign i_cfg.ready = 1'b1;
    assign cfg_wr      = i_cfg.valid;
    assign i_in.ready  = !i_q_full && !cfg_wr;
    assign take        = i_in.valid && !i_q_full && !cfg_wr;

    assign b      = i_in.in_byte;
    assign eob    = i_in.end_of_buffer;
    assign w32    = {r_held, b};
    assign code4  = {w32[26:24], w32[21:16], w32[13:8], w32[5:0]};
    assign d4     = code4 - utf_pkg::SUPP_BASE;
    assign u3     = {w32[19:16], w32[13:8], w32[5:0]};
    assign u2     = {5'd0, w32[12:8], w32[5:0]};
    assign uc     = r_be ? {r_held[7:0], b} : {b, r_held[7:0]};
    assign code_p = {1'b0, r_pend, uc[9:0]} + utf_pkg::SUPP_BASE;
    assign n_cnt  = {1'b0, r_held_cnt} + 3'd1;

    always_comb begin
        n_mode     = r_mode;
        n_be       = r_be;
        n_held     = r_held;
        n_held_cnt = r_held_cnt;
        n_seq_len  = r_seq_len;
        n_pend     = r_pend;
        n_have_hi  = r_have_hi;
        n_disc     = r_disc;
        run        = '0;
        has_run    = 1'b0;
        do_fail    = 1'b0;
        fail_st    = utf_pkg::ST_OK;

        if (cfg_wr) begin
            unique case (i_cfg.reg_index)
                utf_pkg::REG_CONV_MODE:  n_mode = i_cfg.wr_data[1:0];
                utf_pkg::REG_BYTE_ORDER: n_be   = i_cfg.wr_data[0];
                default: ;
            endcase
            n_held     = '0;
            n_held_cnt = '0;
            n_seq_len  = '0;
            n_pend     = '0;
            n_have_hi  = 1'b0;
            n_disc     = 1'b0;
        end else if (take) begin
            if (r_mode == utf_pkg::MODE_COPY) begin
                run.bytes[0]   = b;
                run.last_idx   = 2'd0;
                run.byte_valid = 1'b1;
                has_run        = 1'b1;
            end else if (r_disc) begin
                // drop everything up to the end-of-buffer byte
                if (eob) begin
                    n_held     = '0;
                    n_held_cnt = '0;
                    n_seq_len  = '0;
                    n_pend     = '0;
                    n_have_hi  = 1'b0;
                    n_disc     = 1'b0;
                end
            end else if (r_mode == utf_pkg::MODE_8_TO_16) begin
                if (r_held_cnt == 2'd0) begin
                    if ((b & 8'hF8) == 8'hF0) begin
                        n_seq_len = 3'd4;
                    end else if ((b & 8'hF0) == 8'hE0) begin
                        n_seq_len = 3'd3;
                    end else begin
                        n_seq_len = 3'd2;
                    end
                    if ((b & 8'h80) == 8'h00) begin
                        n_seq_len = r_seq_len;
                        run       = utf_pkg::unit_run({8'd0, b}, r_be);
                        has_run   = 1'b1;
                    end else if ((b & 8'hE0) != 8'hC0 && (b & 8'hF0) != 8'hE0
                                 && (b & 8'hF8) != 8'hF0) begin
                        do_fail = 1'b1;
                        fail_st = utf_pkg::ST_BAD_LEAD;
                    end else begin
                        n_held     = {16'd0, b};
                        n_held_cnt = 2'd1;
                        do_fail    = eob;
                        fail_st    = utf_pkg::ST_TRUNCATED;
                    end
                end else if (n_cnt < r_seq_len) begin
                    n_held     = {r_held[15:0], b};
                    n_held_cnt = n_cnt[1:0];
                    do_fail    = eob;
                    fail_st    = utf_pkg::ST_TRUNCATED;
                end else begin
                    n_held     = '0;
                    n_held_cnt = '0;
                    n_seq_len  = '0;
                    has_run    = 1'b1;
                    if (r_seq_len >= 3'd4) begin
                        run = utf_pkg::pair_run({utf_pkg::HI_SURR_TAG, d4[19:10]},
                                                {utf_pkg::LO_SURR_TAG, d4[9:0]}, r_be);
                    end else if (r_seq_len == 3'd3) begin
                        run = utf_pkg::unit_run(u3, r_be);
                    end else begin
                        run = utf_pkg::unit_run(u2, r_be);
                    end
                end
            end else if (r_mode == utf_pkg::MODE_16_TO_8) begin
                if (r_held_cnt == 2'd0) begin
                    n_held     = {16'd0, b};
                    n_held_cnt = 2'd1;
                    do_fail    = eob;
                    fail_st    = utf_pkg::ST_TRUNCATED;
                end else begin
                    n_held     = '0;
                    n_held_cnt = '0;
                    if (r_have_hi) begin
                        if (uc[15:10] != utf_pkg::LO_SURR_TAG) begin
                            do_fail = 1'b1;
                            fail_st = utf_pkg::ST_BAD_SURR;
                        end else begin
                            n_have_hi      = 1'b0;
                            n_pend         = '0;
                            run.bytes[0]   = {5'b11110, code_p[20:18]};
                            run.bytes[1]   = {2'b10, code_p[17:12]};
                            run.bytes[2]   = {2'b10, code_p[11:6]};
                            run.bytes[3]   = {2'b10, code_p[5:0]};
                            run.last_idx   = 2'd3;
                            run.byte_valid = 1'b1;
                            has_run        = 1'b1;
                        end
                    end else if (uc[15:10] == utf_pkg::LO_SURR_TAG) begin
                        do_fail = 1'b1;
                        fail_st = utf_pkg::ST_BAD_SURR;
                    end else if (uc[15:10] == utf_pkg::HI_SURR_TAG) begin
                        n_pend    = uc[9:0];
                        n_have_hi = 1'b1;
                        do_fail   = eob;
                        fail_st   = utf_pkg::ST_TRUNCATED;
                    end else if (uc[15:7] == 9'd0) begin
                        run.bytes[0]   = uc[7:0];
                        run.last_idx   = 2'd0;
                        run.byte_valid = 1'b1;
                        has_run        = 1'b1;
                    end else if (uc[15:11] == 5'd0) begin
                        run.bytes[0]   = {3'b110, uc[10:6]};
                        run.bytes[1]   = {2'b10, uc[5:0]};
                        run.last_idx   = 2'd1;
                        run.byte_valid = 1'b1;
                        has_run        = 1'b1;
                    end else begin
                        run.bytes[0]   = {4'b1110, uc[15:12]};
                        run.bytes[1]   = {2'b10, uc[11:6]};
                        run.bytes[2]   = {2'b10, uc[5:0]};
                        run.last_idx   = 2'd2;
                        run.byte_valid = 1'b1;
                        has_run        = 1'b1;
                    end
                end
            end else begin
                if (r_held_cnt == 2'd0) begin
                    n_held     = {16'd0, b};
                    n_held_cnt = 2'd1;
                    do_fail    = eob;
                    fail_st    = utf_pkg::ST_TRUNCATED;
                end else begin
                    run.bytes[0]   = b;
                    run.bytes[1]   = r_held[7:0];
                    run.last_idx   = 2'd1;
                    run.byte_valid = 1'b1;
                    has_run        = 1'b1;
                    n_held         = '0;
                    n_held_cnt     = '0;
                end
            end

            // failure: clear the stream, report status only
            if (do_fail) begin
                n_held     = '0;
                n_held_cnt = '0;
                n_seq_len  = '0;
                n_pend     = '0;
                n_have_hi  = 1'b0;
                n_disc     = (fail_st != utf_pkg::ST_TRUNCATED) && !eob;
                run        = '0;
                run.status = fail_st;
                has_run    = 1'b1;
            end
        end
    end

    assign o_push = has_run;
    assign o_run  = run;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= utf_pkg::MODE_COPY;
            r_be       <= 1'b0;
            r_held     <= '0;
            r_held_cnt <= '0;
            r_seq_len  <= '0;
            r_pend     <= '0;
            r_have_hi  <= 1'b0;
            r_disc     <= 1'b0;
        end else begin
            r_mode     <= n_mode;
            r_be       <= n_be;
            r_held     <= n_held;
            r_held_cnt <= n_held_cnt;
            r_seq_len  <= n_seq_len;
            r_pend     <= n_pend;
            r_have_hi  <= n_have_hi;
            r_disc     <= n_disc;
        end
    end

endmodule

FILE: hw/rtl/utf_runq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Run queue
// Small FIFO of run descriptors between the front end and the back end.
// ----------------------------------------------------------------------------
module utf_runq #(
    parameter int DEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  utf_pkg::t_run i_run,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_valid,
    output utf_pkg::t_run o_head
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    utf_pkg::t_run    r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    assign o_full  = (r_cnt == FULL_CNT);
    assign o_valid = (r_cnt != '0);
    assign o_head  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_cnt    = r_cnt;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_run;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

endmodule

FILE: hw/rtl/utf_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Converter back end
// Unrolls each queued run into single results behind an output register.
// ----------------------------------------------------------------------------
module utf_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_valid,
    input  utf_pkg::t_run i_head,
    output logic          o_pop,
    utf_out_if.source     o_out
);

    logic [1:0] r_idx, n_idx;
    logic       r_valid, n_valid;
    logic [7:0] r_byte;
    logic       r_bv;
    logic [1:0] r_st;
    logic       r_last;
    logic       load;
    logic       head_last;

    assign head_last = (r_idx == i_head.last_idx);
    assign load      = i_q_valid && (!r_valid || o_out.ready);
    assign o_pop     = load && head_last;

    always_comb begin
        n_idx   = r_idx;
        n_valid = r_valid;
        if (load) begin
            n_valid = 1'b1;
            n_idx   = head_last ? 2'd0 : r_idx + 2'd1;
        end else if (o_out.ready) begin
            n_valid = 1'b0;
        end
    end

    // payload: advance on every load
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte <= i_head.bytes[r_idx];
            r_bv   <= i_head.byte_valid;
            r_st   <= i_head.status;
            r_last <= head_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_idx   <= n_idx;
            r_valid <= n_valid;
        end
    end

    assign o_out.valid       = r_valid;
    assign o_out.out_byte    = r_byte;
    assign o_out.byte_valid  = r_bv;
    assign o_out.status      = r_st;
    assign o_out.last_of_run = r_last;

endmodule

FILE: hw/rtl/utf8_utf16_stream_converter_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 / UTF-16 stream converter
// Byte-serial transcoder: copy, UTF-8 to UTF-16, UTF-16 to UTF-8, unit swap.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Payload                                    Transfer when
//  i_in     in   in_byte[7:0], end_of_buffer                valid && ready
//  o_out    out  out_byte[7:0], byte_valid, status[1:0],    valid && ready
//                last_of_run
//  i_cfg    in   reg_index[0], wr_data[1:0]                 valid && ready
//
//  The front end takes one byte per cycle while the run queue has room and
//  no config write is offered, and turns it into a run of zero to four
//  results in that same cycle.
//  The back end sends one result per cycle through its output register while
//  o_out is ready; the back end sets the sustained rate, the queue absorbs
//  bursts of short runs.
//  The first result of a byte passes through the run queue, then the output register.
//  Reset is synchronous and active low; it clears the config, the stream state,
//  the queue and the output valid, not the payload. Config is always ready and
//  clears the stream state; i_in.ready drops while a config write is offered.
//  A stall at o_out holds the output register, then fills the queue, then
//  drops i_in.ready; the two ends stall on their own otherwise.
//
module utf8_utf16_stream_converter_top #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    utf_in_if.sink    i_in,
    utf_cfg_if.sink   i_cfg,
    utf_out_if.source o_out
);

    // front to queue
    logic          push;
    utf_pkg::t_run push_run;
    logic          q_full;

    // queue to back
    logic          q_valid;
    utf_pkg::t_run head_run;
    logic          pop;

    // classify each byte, update stream state, build its run
    utf_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_cfg    (i_cfg),
        .i_q_full (q_full),
        .o_push   (push),
        .o_run    (push_run)
    );

    // decouple the two ends
    utf_runq #(
        .DEPTH (QUEUE_DEPTH)
    ) u_runq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_run   (push_run),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_head  (head_run)
    );

    // unroll runs into results, one per cycle while o_out is ready
    utf_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_head    (head_run),
        .o_pop     (pop),
        .o_out     (o_out)
    );

endmodule

FILE: hw/rtl/utf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Converter port checker
// Watches the result channel of the converter top level.
// ----------------------------------------------------------------------------
module utf_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       i_ready,
    input logic [7:0] i_out_byte,
    input logic       i_byte_valid,
    input logic [1:0] i_status,
    input logic       i_last_of_run
);

    // nothing is offered right after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_valid)
        else $error("result offered after reset");

    // a status-only result is alone in its run and carries a zero byte
    a_status_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_byte_valid |-> i_last_of_run && i_out_byte == 8'd0
                                     && i_status != utf_pkg::ST_OK)
        else $error("malformed status result");

    // data results always report ok
    a_data_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_byte_valid |-> i_status == utf_pkg::ST_OK)
        else $error("data result with error status");

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_out_byte)
                                && $stable(i_byte_valid) && $stable(i_last_of_run))
        else $error("stalled result changed");

endmodule

bind utf8_utf16_stream_converter_top utf_checker u_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (o_out.valid),
    .i_ready       (o_out.ready),
    .i_out_byte    (o_out.out_byte),
    .i_byte_valid  (o_out.byte_valid),
    .i_status      (o_out.status),
    .i_last_of_run (o_out.last_of_run)
);
